// ===== design/graph_adjacency_code_decoder_defines.svh =====
// Assertion macros shared by the graph adjacency code decoder modules.
// Each macro expects signals named clock and reset in the including module.
`ifndef GRAPH_ADJACENCY_CODE_DECODER_DEFINES_SVH
`define GRAPH_ADJACENCY_CODE_DECODER_DEFINES_SVH

// Condition holds at every edge outside reset.
`define GACD_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define GACD_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define GACD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/gacd_pkg.sv =====
// Shared types and constants of the graph adjacency code decoder.
// No dependencies.
package gacd_pkg;

   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 16;
   localparam int KIND_W      = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KIND_W-1:0] KIND_EDGE      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SEMI      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_END       = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ORDER_ERR = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ENTRY_ERR = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_BE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ORDER  = 2'd1;

   localparam logic [WORD_W-1:0] MAX_ORDER_RESET = 16'd32;

   // Classified value handed from the front to the back.
   typedef struct packed {
      logic              is_order;
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] vertex;
      logic [WORD_W-1:0] order;
   } tok_type;

endpackage

// ===== design/gacd_ifs.sv =====
// Channel interfaces of the graph adjacency code decoder.
// Depends on gacd_pkg.
interface gacd_req_if;
   logic                       valid;
   logic                       ready;
   logic [gacd_pkg::BYTE_W-1:0] in_byte;
   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface gacd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [gacd_pkg::KIND_W-1:0] kind;
   logic [gacd_pkg::WORD_W-1:0] vertex_a;
   logic [gacd_pkg::WORD_W-1:0] vertex_b;
   logic [gacd_pkg::WORD_W-1:0] graph_order;
   modport source (output valid, output kind, output vertex_a, output vertex_b,
                   output graph_order, input ready);
   modport sink (input valid, input kind, input vertex_a, input vertex_b,
                 input graph_order, output ready);
endinterface

interface gacd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [gacd_pkg::CSR_IDX_W-1:0]  index;
   logic [gacd_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/gacd_front.sv =====
// Front of the decoder: header parsing, byte pairing and graph framing.
// Depends on gacd_pkg; pushes classified values into the queue.
module gacd_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        byte_valid,
   input  logic [gacd_pkg::BYTE_W-1:0] byte_data,
   input  logic                        default_be,
   input  logic [gacd_pkg::WORD_W-1:0] max_order,
   output logic                        push,
   output gacd_pkg::tok_type           push_tok
);

   localparam logic [2:0] PH_HDR_FIRST  = 3'd0;
   localparam logic [2:0] PH_HDR_SECOND = 3'd1;
   localparam logic [2:0] PH_HDR_SKIP   = 3'd2;
   localparam logic [2:0] PH_ORDER      = 3'd3;
   localparam logic [2:0] PH_ORDER_HI   = 3'd4;
   localparam logic [2:0] PH_ORDER_LO   = 3'd5;
   localparam logic [2:0] PH_ENTRY      = 3'd6;
   localparam logic [2:0] PH_ENTRY_LO   = 3'd7;

   localparam logic [gacd_pkg::BYTE_W-1:0] CH_L  = 8'h6C;
   localparam logic [gacd_pkg::BYTE_W-1:0] CH_B  = 8'h62;
   localparam logic [gacd_pkg::BYTE_W-1:0] CH_E  = 8'h65;
   localparam logic [gacd_pkg::BYTE_W-1:0] CH_LT = 8'h3C;

   logic [2:0]                  phase_ff, phase_in;
   logic [gacd_pkg::BYTE_W-1:0] last_ff, last_in;
   logic                        big_ff, big_in;
   logic                        two_ff, two_in;
   logic [gacd_pkg::BYTE_W-1:0] pending_ff, pending_in;
   logic [gacd_pkg::WORD_W-1:0] order_ff, order_in;
   logic [gacd_pkg::WORD_W-1:0] vertex_ff, vertex_in;
   logic                        halted_ff, halted_in;

   logic [gacd_pkg::WORD_W-1:0] word;
   logic [gacd_pkg::WORD_W-1:0] byte_word;
   logic [gacd_pkg::WORD_W-1:0] ord_n;
   logic [gacd_pkg::WORD_W-1:0] ent_v;
   logic [gacd_pkg::WORD_W:0]   ent_np1;
   logic [gacd_pkg::WORD_W-1:0] vertex_inc;
   logic                        is_space;
   logic                        lt_pair;
   logic                        do_start;
   logic                        do_take;

   assign word       = big_ff ? {pending_ff, byte_data} : {byte_data, pending_ff};
   assign byte_word  = {{(gacd_pkg::WORD_W-gacd_pkg::BYTE_W){1'b0}}, byte_data};
   assign ord_n      = (phase_ff == PH_ORDER_LO) ? word : byte_word;
   assign ent_v      = (phase_ff == PH_ENTRY_LO) ? word : byte_word;
   assign ent_np1    = {1'b0, order_ff} + 1'b1;
   assign vertex_inc = vertex_ff + 1'b1;
   assign is_space   = (byte_data == 8'h20) || ((byte_data >= 8'h09) && (byte_data <= 8'h0D));
   assign lt_pair    = (last_ff == CH_LT) && (byte_data == CH_LT);

   always_comb begin
      phase_in   = phase_ff;
      last_in    = last_ff;
      big_in     = big_ff;
      two_in     = two_ff;
      pending_in = pending_ff;
      order_in   = order_ff;
      vertex_in  = vertex_ff;
      halted_in  = halted_ff;
      do_start   = 1'b0;
      do_take    = 1'b0;
      push       = 1'b0;
      push_tok   = '{is_order: 1'b0, value: ent_v, vertex: vertex_ff, order: order_ff};

      if (byte_valid && !halted_ff) begin
         unique case (phase_ff)
            PH_HDR_FIRST: begin
               if (!is_space) begin
                  last_in  = byte_data;
                  phase_in = PH_HDR_SECOND;
               end
            end
            PH_HDR_SECOND: begin
               priority if (last_ff == CH_L && byte_data == CH_E) begin
                  big_in = 1'b0;
               end else if (last_ff == CH_B && byte_data == CH_E) begin
                  big_in = 1'b1;
               end else begin
                  big_in = default_be;
               end
               phase_in = lt_pair ? PH_ORDER : PH_HDR_SKIP;
               last_in  = byte_data;
            end
            PH_HDR_SKIP: begin
               if (lt_pair) begin
                  phase_in = PH_ORDER;
               end
               last_in = byte_data;
            end
            PH_ORDER: begin
               if (byte_data == '0) begin
                  two_in   = 1'b1;
                  phase_in = PH_ORDER_HI;
               end else begin
                  two_in   = 1'b0;
                  do_start = 1'b1;
               end
            end
            PH_ORDER_HI: begin
               pending_in = byte_data;
               phase_in   = PH_ORDER_LO;
            end
            PH_ORDER_LO: begin
               do_start = 1'b1;
            end
            PH_ENTRY: begin
               if (two_ff) begin
                  pending_in = byte_data;
                  phase_in   = PH_ENTRY_LO;
               end else begin
                  do_take = 1'b1;
               end
            end
            PH_ENTRY_LO: begin
               do_take = 1'b1;
            end
         endcase
      end

      if (do_start) begin
         push_tok = '{is_order: 1'b1, value: ord_n, vertex: '0, order: ord_n};
         if (ord_n > max_order) begin
            halted_in = 1'b1;
            push      = 1'b1;
         end else begin
            order_in  = ord_n;
            vertex_in = '0;
            if (ord_n == '0) begin
               phase_in = PH_ORDER;
               push     = 1'b1;
            end else begin
               phase_in = PH_ENTRY;
            end
         end
      end

      if (do_take) begin
         phase_in = PH_ENTRY;
         if (ent_v == '0) begin
            vertex_in = vertex_inc;
            if (vertex_inc >= order_ff) begin
               phase_in = PH_ORDER;
               push     = 1'b1;
            end
         end else begin
            push = 1'b1;
            if ({1'b0, ent_v} > ent_np1) begin
               halted_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR_FIRST;
         last_ff   <= '0;
         big_ff    <= 1'b0;
         two_ff    <= 1'b0;
         order_ff  <= '0;
         vertex_ff <= '0;
         halted_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         last_ff   <= last_in;
         big_ff    <= big_in;
         two_ff    <= two_in;
         order_ff  <= order_in;
         vertex_ff <= vertex_in;
         halted_ff <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      pending_ff <= pending_in;
   end

endmodule

// ===== design/gacd_queue.sv =====
// Two-entry queue between the decoder front and back.
// Depends on gacd_pkg and the assertion macro header.
`include "graph_adjacency_code_decoder_defines.svh"

module gacd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gacd_pkg::tok_type push_tok,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output gacd_pkg::tok_type pop_tok
);

   gacd_pkg::tok_type               mem_ff [gacd_pkg::QUEUE_DEPTH];
   logic [gacd_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [gacd_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [gacd_pkg::QCNT_W-1:0]     count_ff, count_in;

   assign full      = (count_ff == gacd_pkg::QCNT_W'(gacd_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_tok   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_tok;
      end
   end

   `GACD_ASSERT_IMPL(a_no_pop_empty, pop, not_empty, "queue popped while empty")
   `GACD_ASSERT_IMPL(a_no_push_full, push, !full, "queue pushed while full")

endmodule

// ===== design/gacd_back.sv =====
// Back of the decoder: turns queued values into result transactions.
// Depends on gacd_pkg and the assertion macro header.
`include "graph_adjacency_code_decoder_defines.svh"

module gacd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        tok_valid,
   input  gacd_pkg::tok_type           tok,
   input  logic [gacd_pkg::WORD_W-1:0] max_order,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [gacd_pkg::KIND_W-1:0] rsp_kind,
   output logic [gacd_pkg::WORD_W-1:0] rsp_vertex_a,
   output logic [gacd_pkg::WORD_W-1:0] rsp_vertex_b,
   output logic [gacd_pkg::WORD_W-1:0] rsp_graph_order
);

   logic                        valid_ff, valid_in;
   logic [gacd_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [gacd_pkg::WORD_W-1:0] va_ff, va_in;
   logic [gacd_pkg::WORD_W-1:0] vb_ff, vb_in;
   logic [gacd_pkg::WORD_W-1:0] go_ff, go_in;
   logic [gacd_pkg::WORD_W:0]   np1;
   logic [gacd_pkg::WORD_W:0]   v_ext;

   assign np1   = {1'b0, tok.order} + 1'b1;
   assign v_ext = {1'b0, tok.value};
   assign pop   = tok_valid && (!valid_ff || rsp_ready);

   always_comb begin
      kind_in = gacd_pkg::KIND_END;
      va_in   = '0;
      vb_in   = '0;
      go_in   = tok.order;
      priority if (tok.is_order) begin
         if (tok.value > max_order) begin
            kind_in = gacd_pkg::KIND_ORDER_ERR;
         end else begin
            go_in = '0;
         end
      end else if (tok.value == '0) begin
         kind_in = gacd_pkg::KIND_END;
      end else if (v_ext == np1) begin
         kind_in = gacd_pkg::KIND_SEMI;
         va_in   = tok.vertex;
         vb_in   = tok.order;
      end else if (v_ext > np1) begin
         kind_in = gacd_pkg::KIND_ENTRY_ERR;
      end else begin
         kind_in = gacd_pkg::KIND_EDGE;
         va_in   = tok.vertex;
         vb_in   = tok.value - 1'b1;
      end
      valid_in = pop ? 1'b1 : (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff <= kind_in;
         va_ff   <= va_in;
         vb_ff   <= vb_in;
         go_ff   <= go_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_vertex_a    = va_ff;
   assign rsp_vertex_b    = vb_ff;
   assign rsp_graph_order = go_ff;

   `GACD_ASSERT_NEXT(a_pop_loads, pop, valid_ff, "popped value did not reach output")
   `GACD_ASSERT_IMPL(a_err_zero, valid_ff && (kind_ff == gacd_pkg::KIND_ORDER_ERR || kind_ff == gacd_pkg::KIND_ENTRY_ERR), va_ff == '0 && vb_ff == '0, "error result carries vertices")
   `GACD_ASSERT_IMPL(a_edge_range, valid_ff && kind_ff == gacd_pkg::KIND_EDGE, vb_ff < go_ff && va_ff < go_ff, "edge vertex out of range")
   `GACD_ASSERT_IMPL(a_semi_order, valid_ff && kind_ff == gacd_pkg::KIND_SEMI, vb_ff == go_ff, "semi-edge without graph order")

endmodule

// ===== design/graph_adjacency_code_decoder.sv =====
// Graph adjacency code decoder: byte stream in, decoded edges out.
// req_chan carries one stream byte per transaction; rsp_chan carries one result
// (edge, semi-edge, graph end, order error, entry error) per transaction;
// csr_chan writes index 0 (default byte order, 1 = big) and index 1 (max order).
// csr_chan is always ready; write it only while the decoder is idle.
// Throughput: one byte per cycle while the queue is not full. The front classifies a byte
// in the cycle it is accepted and hands any result-producing value to a two-entry queue;
// the back moves it from the queue into the output register once that register is free,
// and the output register drives rsp_chan valid.
// When rsp_chan stalls, the output register holds and the queue fills; req_chan
// ready drops only while the queue is full, and returns as soon as a result
// leaves.
// Reset: synchronous, active high. Clears the header parser, byte order, graph
// framing, queue and output valid, and restores register defaults (little
// endian, max order 32). After an order or entry error every byte is accepted
// and dropped until reset.
module graph_adjacency_code_decoder (
   input  logic              clock,
   input  logic              reset,
   gacd_req_if.sink          req_chan,
   gacd_rsp_if.source        rsp_chan,
   gacd_csr_if.sink          csr_chan
);

   logic                        default_be_ff;
   logic [gacd_pkg::WORD_W-1:0] max_order_ff;
   logic                        push;
   logic                        pop;
   logic                        full;
   logic                        not_empty;
   gacd_pkg::tok_type           push_tok;
   gacd_pkg::tok_type           pop_tok;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_be_ff <= 1'b0;
         max_order_ff  <= gacd_pkg::MAX_ORDER_RESET;
      end else if (csr_chan.valid) begin
         if (csr_chan.index == gacd_pkg::CSR_DEFAULT_BE) begin
            default_be_ff <= csr_chan.data[0];
         end
         if (csr_chan.index == gacd_pkg::CSR_MAX_ORDER) begin
            max_order_ff <= csr_chan.data[gacd_pkg::WORD_W-1:0];
         end
      end
   end

   gacd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_chan.valid && !full),
      .byte_data  (req_chan.in_byte),
      .default_be (default_be_ff),
      .max_order  (max_order_ff),
      .push       (push),
      .push_tok   (push_tok)
   );

   gacd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_tok  (push_tok),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .pop_tok   (pop_tok)
   );

   gacd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .tok_valid       (not_empty),
      .tok             (pop_tok),
      .max_order       (max_order_ff),
      .pop             (pop),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_kind        (rsp_chan.kind),
      .rsp_vertex_a    (rsp_chan.vertex_a),
      .rsp_vertex_b    (rsp_chan.vertex_b),
      .rsp_graph_order (rsp_chan.graph_order)
   );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for graph_adjacency_code_decoder: drives a byte stream of graphs,
// predicts every edge, semi-edge, graph end and error result, and checks each one.
// Depends on gacd_pkg and the channel interfaces in gacd_ifs.
`timescale 1ns / 100ps

module tb_top;
   import gacd_pkg::*;

   localparam int ITEM_TARGET  = 1520;
   localparam int DRAIN_CYCLES = 6;
   localparam int MAX_REPORTS  = 200;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
   localparam logic [BYTE_W-1:0] CH_L     = 8'h6C;
   localparam logic [BYTE_W-1:0] CH_B     = 8'h62;
   localparam logic [BYTE_W-1:0] CH_E     = 8'h65;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

   typedef enum logic [2:0] {
      DEC_HDR_FIRST, DEC_HDR_SECOND, DEC_HDR_SKIP, DEC_ORDER,
      DEC_ORDER_HI, DEC_ORDER_LO, DEC_ENTRY, DEC_ENTRY_LO
   } dec_phase_e;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] vertex_a;
      logic [WORD_W-1:0] vertex_b;
      logic [WORD_W-1:0] graph_order;
   } dec_result_t;

   logic clock;
   logic reset;

   gacd_req_if req_if ();
   gacd_rsp_if rsp_if ();
   gacd_csr_if csr_if ();

   graph_adjacency_code_decoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // decoder state as the bench tracks it
   logic              cfg_default_be = 1'b0;
   logic [WORD_W-1:0] cfg_max_order  = MAX_ORDER_RESET;
   dec_phase_e        dec_phase      = DEC_HDR_FIRST;
   logic [BYTE_W-1:0] hdr_prev       = '0;
   logic              big_order      = 1'b0;
   logic              wide_entries   = 1'b0;
   logic [BYTE_W-1:0] held_byte      = '0;
   logic [WORD_W-1:0] cur_order      = '0;
   logic [WORD_W-1:0] cur_vertex     = '0;
   logic              stopped        = 1'b0;

   dec_result_t awaited_results[$];

   int fail_count  = 0;
   int bytes_sent  = 0;
   int burst_left  = 0;
   int gap_max     = 0;
   int stall_pct   = 0;
   int stall_left  = 0;
   int wide_graphs = 0;

   function automatic bit is_blank(logic [BYTE_W-1:0] b);
      return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
   endfunction

   function automatic logic [WORD_W-1:0] join_pair(logic [BYTE_W-1:0] first,
                                                   logic [BYTE_W-1:0] second);
      return big_order ? {first, second} : {second, first};
   endfunction

   function automatic void push_result(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] a,
                                       logic [WORD_W-1:0] b, logic [WORD_W-1:0] n);
      dec_result_t r;
      r.kind        = kind;
      r.vertex_a    = a;
      r.vertex_b    = b;
      r.graph_order = n;
      awaited_results.push_back(r);
   endfunction

   function automatic void begin_graph(logic [WORD_W-1:0] n);
      if (n > cfg_max_order) begin
         stopped = 1'b1;
         push_result(KIND_ORDER_ERR, '0, '0, n);
      end else begin
         cur_order  = n;
         cur_vertex = '0;
         if (n == '0) begin
            dec_phase = DEC_ORDER;
            push_result(KIND_END, '0, '0, '0);
         end else begin
            dec_phase = DEC_ENTRY;
         end
      end
   endfunction

   function automatic void apply_entry(logic [WORD_W-1:0] v);
      logic [WORD_W:0] semi_code;
      semi_code = {1'b0, cur_order} + 1'b1;
      dec_phase = DEC_ENTRY;
      if (v == '0) begin
         cur_vertex = cur_vertex + 1'b1;
         if (cur_vertex >= cur_order) begin
            dec_phase = DEC_ORDER;
            push_result(KIND_END, '0, '0, cur_order);
         end
      end else if ({1'b0, v} == semi_code) begin
         push_result(KIND_SEMI, cur_vertex, cur_order, cur_order);
      end else if ({1'b0, v} > semi_code) begin
         stopped = 1'b1;
         push_result(KIND_ENTRY_ERR, '0, '0, cur_order);
      end else begin
         push_result(KIND_EDGE, cur_vertex, v - 1'b1, cur_order);
      end
   endfunction

   function automatic void decode_byte(logic [BYTE_W-1:0] b);
      if (stopped) return;
      case (dec_phase)
         DEC_HDR_FIRST: begin
            if (!is_blank(b)) begin
               hdr_prev  = b;
               dec_phase = DEC_HDR_SECOND;
            end
         end
         DEC_HDR_SECOND: begin
            if (hdr_prev == CH_L && b == CH_E) big_order = 1'b0;
            else if (hdr_prev == CH_B && b == CH_E) big_order = 1'b1;
            else big_order = cfg_default_be;
            dec_phase = (hdr_prev == CH_LT && b == CH_LT) ? DEC_ORDER : DEC_HDR_SKIP;
            hdr_prev  = b;
         end
         DEC_HDR_SKIP: begin
            if (hdr_prev == CH_LT && b == CH_LT) dec_phase = DEC_ORDER;
            hdr_prev = b;
         end
         DEC_ORDER: begin
            if (b == '0) begin
               wide_entries = 1'b1;
               dec_phase    = DEC_ORDER_HI;
            end else begin
               wide_entries = 1'b0;
               begin_graph({8'h00, b});
            end
         end
         DEC_ORDER_HI: begin
            held_byte = b;
            dec_phase = DEC_ORDER_LO;
         end
         DEC_ORDER_LO: begin
            begin_graph(join_pair(held_byte, b));
         end
         DEC_ENTRY: begin
            if (wide_entries) begin
               held_byte = b;
               dec_phase = DEC_ENTRY_LO;
            end else begin
               apply_entry({8'h00, b});
            end
         end
         default: begin
            apply_entry(join_pair(held_byte, b));
         end
      endcase
   endfunction

   function automatic void report_field(string name, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result channel stalls in runs of random length
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 6);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      dec_result_t want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_results.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $error("result transaction with none expected: kind %0d", rsp_if.kind);
         end else begin
            want = awaited_results.pop_front();
            report_field("kind", WORD_W'(want.kind), WORD_W'(rsp_if.kind));
            report_field("vertex_a", want.vertex_a, rsp_if.vertex_a);
            report_field("vertex_b", want.vertex_b, rsp_if.vertex_b);
            report_field("graph_order", want.graph_order, rsp_if.graph_order);
         end
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      csr_if.valid   <= 1'b0;
      req_if.valid   <= 1'b1;
      req_if.in_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      decode_byte(b);
      bytes_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_word(input logic [WORD_W-1:0] w);
      if (big_order) begin
         send_byte(w[15:8]);
         send_byte(w[7:0]);
      end else begin
         send_byte(w[7:0]);
         send_byte(w[15:8]);
      end
   endtask

   task automatic send_order(input bit wide, input logic [WORD_W-1:0] n);
      if (wide) begin
         send_byte(8'h00);
         send_word(n);
      end else begin
         send_byte(n[7:0]);
      end
   endtask

   task automatic send_entry(input bit wide, input logic [WORD_W-1:0] v);
      if (wide) send_word(v);
      else send_byte(v[7:0]);
   endtask

   task automatic send_graph(input bit wide, input logic [WORD_W-1:0] n, input int per_vertex);
      int k;
      send_order(wide, n);
      for (int v = 0; v < n; v++) begin
         k = $urandom_range(0, per_vertex);
         repeat (k) begin
            if ($urandom_range(0, 5) == 0) send_entry(wide, n + 1'b1);
            else send_entry(wide, WORD_W'($urandom_range(1, n)));
         end
         send_entry(wide, '0);
      end
   endtask

   // hold both senders idle until all results are back and the pipeline is empty
   task automatic wait_results_drained();
      req_if.valid <= 1'b0;
      csr_if.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      if (idx == CSR_DEFAULT_BE) cfg_default_be = data[0];
      else if (idx == CSR_MAX_ORDER) cfg_max_order = data;
   endtask

   task automatic test_unused_csr_index();
      write_csr(CSR_SPARE_LO, CSR_DATA_W'($urandom_range(0, 65535)));
      write_csr(CSR_SPARE_HI, CSR_DATA_W'($urandom_range(0, 65535)));
      wait_results_drained();
   endtask

   task automatic test_header();
      int variant;
      int n_skip;
      logic [BYTE_W-1:0] first;
      logic [BYTE_W-1:0] second;
      logic [BYTE_W-1:0] filler;
      variant = $urandom_range(0, 3);
      write_csr(CSR_DEFAULT_BE, CSR_DATA_W'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 5) == 0) send_byte(CH_SPACE);
         else send_byte(BYTE_W'($urandom_range(CH_TAB, CH_CR)));
      end
      case (variant)
         0: begin
            first  = CH_L;
            second = CH_E;
         end
         1: begin
            first  = CH_B;
            second = CH_E;
         end
         2: begin
            do first = BYTE_W'($urandom_range(0, 255));
            while (is_blank(first) || first == CH_LT);
            second = BYTE_W'($urandom_range(0, 255));
         end
         default: begin
            first  = CH_LT;
            second = CH_LT;
         end
      endcase
      send_byte(first);
      // the byte order is decided on the second header byte
      wait_results_drained();
      write_csr(CSR_DEFAULT_BE, CSR_DATA_W'($urandom_range(0, 1)));
      send_byte(second);
      if (variant != 3) begin
         send_byte(8'h00);
         send_byte(8'hFF);
         n_skip = $urandom_range(4, 12);
         repeat (n_skip) begin
            do filler = BYTE_W'($urandom_range(0, 255));
            while (filler == CH_LT);
            send_byte(filler);
         end
         send_byte(CH_LT);
         send_byte(CH_LT);
      end
   endtask

   task automatic test_directed_graphs();
      send_byte(8'd1);
      send_byte(8'd1);
      send_byte(8'd2);
      send_byte(8'd0);
      send_order(1'b1, 16'd0);
      send_order(1'b1, 16'd2);
      send_word(16'd3);
      send_word(16'd2);
      send_word(16'd0);
      send_word(16'd1);
      send_word(16'd0);
   endtask

   task automatic test_random_graphs();
      int phase_no;
      int phase_stop;
      int r;
      int lim;
      int per_vertex;
      bit wide;
      logic [WORD_W-1:0] n;
      phase_no = 0;
      while (bytes_sent < ITEM_TARGET) begin
         wait_results_drained();
         case (phase_no)
            0: write_csr(CSR_MAX_ORDER, 16'd1);
            1: write_csr(CSR_MAX_ORDER, 16'hFFFF);
            default: begin
               case ($urandom_range(0, 3))
                  0: write_csr(CSR_MAX_ORDER, CSR_DATA_W'($urandom_range(1, 8)));
                  1: write_csr(CSR_MAX_ORDER, CSR_DATA_W'($urandom_range(9, 255)));
                  2: write_csr(CSR_MAX_ORDER, 16'hFFFF);
                  default: write_csr(CSR_MAX_ORDER, CSR_DATA_W'($urandom_range(256, 65534)));
               endcase
            end
         endcase
         write_csr(CSR_DEFAULT_BE, CSR_DATA_W'($urandom_range(0, 1)));
         if (phase_no == 0) begin
            gap_max   = 0;
            stall_pct = 0;
         end else begin
            r = $urandom_range(0, 2);
            gap_max = (r == 0) ? 0 : (r == 1) ? 2 : 12;
            r = $urandom_range(0, 2);
            stall_pct = (r == 0) ? 0 : (r == 1) ? 25 : 70;
         end
         phase_stop = bytes_sent + $urandom_range(60, 160);
         while (bytes_sent < phase_stop) begin
            wide       = $urandom_range(0, 1);
            lim        = cfg_max_order;
            per_vertex = 4;
            r          = $urandom_range(0, 23);
            if (r == 0 && wide) begin
               n = '0;
            end else if (r == 1 && wide_graphs < 2) begin
               n = wide ? WORD_W'($urandom_range(256, 270)) : 16'd255;
               if (n > lim) n = lim;
               if (n > 24) begin
                  wide_graphs++;
                  per_vertex = 1;
               end
            end else begin
               n = WORD_W'($urandom_range(1, (lim < 24) ? lim : 24));
            end
            send_graph(wide, n, per_vertex);
            if ($urandom_range(0, 7) == 0) wait_results_drained();
         end
         phase_no++;
      end
   endtask

   // an error stops the decoder for good, so this runs last
   task automatic test_error_halt();
      bit wide;
      logic [WORD_W-1:0] n;
      wait_results_drained();
      write_csr(CSR_MAX_ORDER, CSR_DATA_W'($urandom_range(1, 200)));
      wide = $urandom_range(0, 1);
      if ($urandom_range(0, 1)) begin
         if (wide) n = WORD_W'($urandom_range(cfg_max_order + 1, 65535));
         else n = WORD_W'($urandom_range(cfg_max_order + 1, 255));
         send_order(wide, n);
      end else begin
         n = WORD_W'($urandom_range(1, (cfg_max_order < 24) ? cfg_max_order : 24));
         send_order(wide, n);
         repeat ($urandom_range(0, 3)) send_entry(wide, WORD_W'($urandom_range(1, n + 1)));
         if (wide) send_entry(wide, WORD_W'($urandom_range(n + 2, 65535)));
         else send_entry(wide, WORD_W'($urandom_range(n + 2, 255)));
      end
      repeat ($urandom_range(20, 40)) send_byte(BYTE_W'($urandom_range(0, 255)));
   endtask

   initial begin
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.in_byte <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.index   <= CSR_DEFAULT_BE;
      csr_if.data    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_unused_csr_index();
      test_header();
      test_directed_graphs();
      test_random_graphs();
      test_error_halt();
      wait_results_drained();
      if (fail_count == 0) begin
         $display("graph_adjacency_code_decoder regression: pass");
      end else begin
         $display("graph_adjacency_code_decoder regression: fail");
      end
      $finish;
   end

   initial begin
      #(4_000_000);
      $display("graph_adjacency_code_decoder regression: fail");
      $finish;
   end

endmodule
